[hw/rtl/hci_h4_pkg.sv]
// Package for the HCI H4 packet deframer: packet kinds, error and baud action codes,
// H4 and vendor opcode byte values, and the type byte decoder.
// No dependencies.
package hci_h4_pkg;

    localparam int MAX_PACKET_DEF = 8192;
    localparam int NUM_LINES_DEF  = 2;
    localparam int HDR_KEEP       = 9;
    localparam int LINE_W         = 1;
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 3;
    localparam int LEN_W          = 14;
    localparam int ERR_W          = 2;
    localparam int ACT_W          = 2;
    localparam int BAUD_W         = 24;
    localparam logic [BAUD_W-1:0] FALLBACK_BAUD_RST = 24'd115200;

    typedef enum logic [KIND_W-1:0] {
        KIND_CMD    = 3'd0,
        KIND_ACL    = 3'd1,
        KIND_SCO    = 3'd2,
        KIND_EVT    = 3'd3,
        KIND_VENDOR = 3'd4
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE = 2'd0,
        ERR_TYPE = 2'd1,
        ERR_LEN  = 2'd2
    } t_err;

    typedef enum logic [ACT_W-1:0] {
        BAUD_NONE   = 2'd0,
        BAUD_SWITCH = 2'd1,
        BAUD_FAIL   = 2'd2,
        BAUD_REVERT = 2'd3
    } t_baud_act;

    // H4 type bytes
    localparam logic [7:0] H4_PAD    = 8'h00;
    localparam logic [7:0] H4_CMD    = 8'h01;
    localparam logic [7:0] H4_ACL    = 8'h02;
    localparam logic [7:0] H4_SCO    = 8'h03;
    localparam logic [7:0] H4_EVT    = 8'h04;
    localparam logic [7:0] H4_VENDOR = 8'hff;

    // Vendor command / event bytes
    localparam logic [7:0] OCF_SET_BAUD  = 8'h18;
    localparam logic [7:0] OCF_FW_DONE   = 8'h4e;
    localparam logic [7:0] OGF_VENDOR    = 8'hfc;
    localparam logic [7:0] CMD_BAUD_PLEN = 8'h06;
    localparam logic [7:0] EVT_CMD_CPL   = 8'h0e;
    localparam logic [7:0] EVT_CPL_PLEN  = 8'h04;
    localparam logic [7:0] NUM_CMD_PKTS  = 8'h01;
    localparam logic [7:0] STATUS_OK     = 8'h00;

    typedef struct packed {
        logic  ok;
        t_kind kind;
    } t_type_dec;

    function automatic t_type_dec decode_type(input logic [7:0] b);
        t_type_dec d;
        d.ok   = 1'b1;
        d.kind = KIND_CMD;
        unique case (b)
            H4_CMD:    d.kind = KIND_CMD;
            H4_ACL:    d.kind = KIND_ACL;
            H4_SCO:    d.kind = KIND_SCO;
            H4_EVT:    d.kind = KIND_EVT;
            H4_VENDOR: d.kind = KIND_VENDOR;
            default:   d.ok   = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/hci_h4_if.sv]
// Channel interfaces of the HCI H4 deframer: input word, result word, config write.
// Depends on hci_h4_pkg.
interface hci_h4_in_if;
    logic                             valid;
    logic                             ready;
    logic [hci_h4_pkg::LINE_W-1:0]    line_index;
    logic [hci_h4_pkg::BYTE_W-1:0]    data_byte;
    modport source (output valid, line_index, data_byte, input ready);
    modport sink   (input valid, line_index, data_byte, output ready);
endinterface

interface hci_h4_out_if;
    logic                             valid;
    logic                             ready;
    logic [hci_h4_pkg::LINE_W-1:0]    out_line;
    logic [hci_h4_pkg::BYTE_W-1:0]    out_byte;
    logic                             first_of_packet;
    logic                             last_of_packet;
    logic [hci_h4_pkg::KIND_W-1:0]    packet_kind;
    logic                             incoming;
    logic [hci_h4_pkg::LEN_W-1:0]     packet_length;
    logic [hci_h4_pkg::ERR_W-1:0]     error_code;
    logic [hci_h4_pkg::ACT_W-1:0]     baud_action;
    logic [hci_h4_pkg::BAUD_W-1:0]    baud_value;
    modport source (output valid, out_line, out_byte, first_of_packet, last_of_packet,
                    packet_kind, incoming, packet_length, error_code, baud_action,
                    baud_value, input ready);
    modport sink   (input valid, out_line, out_byte, first_of_packet, last_of_packet,
                    packet_kind, incoming, packet_length, error_code, baud_action,
                    baud_value, output ready);
endinterface

interface hci_h4_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hci_h4_pkg::BAUD_W-1:0]    fallback_baud;
    modport source (output valid, fallback_baud, input ready);
    modport sink   (input valid, fallback_baud, output ready);
endinterface

[hw/rtl/hci_h4_packet_deframer_unit.sv]
// HCI H4 deframer top level: per-line state memory, read-modify-write stage, result register.
// Depends on hci_h4_pkg and the interfaces in hci_h4_if.sv.
//
//   channel  dir  handshake      word
//   i_in     in   valid/ready    line_index, data_byte
//   o_out    out  valid/ready    out_line .. baud_value (one word per result)
//   i_cfg    in   valid/ready    fallback_baud (always ready)
//
// One word per cycle sustained while o_out is not stalled; each result is registered after the line-state read.
// Pipeline: line-state memory read, then update and result register.
// Same line on consecutive words: the write-back of the previous word is forwarded.
// Reset clears the per-line valid bits; no memory clearing pass.
// A stalled result holds o_out; the update stage still takes one more word.
module hci_h4_packet_deframer_unit #(
    parameter int MAX_PACKET = hci_h4_pkg::MAX_PACKET_DEF,
    parameter int NUM_LINES  = hci_h4_pkg::NUM_LINES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hci_h4_in_if.sink           i_in,
    hci_h4_out_if.source        o_out,
    hci_h4_cfg_if.sink          i_cfg
);

    localparam int CntW    = $clog2(MAX_PACKET + 1);
    localparam int AddrW   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int AclW    = 17;
    localparam int HdrIdxW = $clog2(hci_h4_pkg::HDR_KEEP);

    typedef struct packed {
        logic [CntW-1:0]                          cnt;
        logic [CntW-1:0]                          exp_len;
        hci_h4_pkg::t_kind                        kind;
        logic                                     dir;
        logic [7:0]                               len_lo;
        logic [hci_h4_pkg::HDR_KEEP-1:0][7:0]     hdr;
    } t_line_st;

    t_line_st                               r_mem [NUM_LINES];
    t_line_st                               r_rd;
    logic [NUM_LINES-1:0]                   r_vld;
    logic                                   r_s1_vld;
    logic [hci_h4_pkg::LINE_W-1:0]          r_s1_line;
    logic [7:0]                             r_s1_byte;
    logic                                   r_fwd_vld;
    logic [hci_h4_pkg::LINE_W-1:0]          r_fwd_line;
    t_line_st                               r_fwd;
    logic [hci_h4_pkg::BAUD_W-1:0]          r_pend_baud;
    logic [hci_h4_pkg::BAUD_W-1:0]          r_fallback;

    logic                                   r_o_vld;
    logic [hci_h4_pkg::LINE_W-1:0]          r_o_line;
    logic [7:0]                             r_o_byte;
    logic                                   r_o_first;
    logic                                   r_o_last;
    hci_h4_pkg::t_kind                      r_o_kind;
    logic                                   r_o_inc;
    logic [hci_h4_pkg::LEN_W-1:0]           r_o_len;
    hci_h4_pkg::t_err                       r_o_err;
    hci_h4_pkg::t_baud_act                  r_o_act;
    logic [hci_h4_pkg::BAUD_W-1:0]          r_o_baud;

    logic                                   in_fire;
    logic                                   s1_adv;
    logic                                   line_ok;
    logic                                   wr_en;
    logic [AddrW-1:0]                       in_addr;
    logic [AddrW-1:0]                       s1_addr;
    t_line_st                               cur_st;

    t_line_st                               n_st;
    logic [hci_h4_pkg::BAUD_W-1:0]          n_pend_baud;
    logic                                   n_o_vld;
    logic                                   n_o_first;
    logic                                   n_o_last;
    hci_h4_pkg::t_kind                      n_o_kind;
    logic                                   n_o_inc;
    logic [hci_h4_pkg::LEN_W-1:0]           n_o_len;
    hci_h4_pkg::t_err                       n_o_err;
    hci_h4_pkg::t_baud_act                  n_o_act;
    logic [hci_h4_pkg::BAUD_W-1:0]          n_o_baud;

    assign s1_adv      = r_s1_vld && (!r_o_vld || o_out.ready);
    assign i_in.ready  = !r_s1_vld || s1_adv;
    assign in_fire     = i_in.valid && i_in.ready;
    assign in_addr     = AddrW'(i_in.line_index);
    assign s1_addr     = AddrW'(r_s1_line);
    assign line_ok     = int'(r_s1_line) < NUM_LINES;
    assign wr_en       = s1_adv && line_ok;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_fwd_vld && (r_fwd_line == r_s1_line)) begin
            cur_st = r_fwd;
        end else if (line_ok && r_vld[s1_addr]) begin
            cur_st = r_rd;
        end else begin
            cur_st = '0;
        end
    end

    // Update stage
    always_comb begin
        logic [CntW-1:0]            pos;
        logic [CntW-1:0]            pos1;
        logic [CntW-1:0]            exp_len;
        logic [AclW-1:0]            acl_len;
        logic                       hunt;
        logic                       last;
        logic                       len_err;
        logic                       dir;
        hci_h4_pkg::t_kind          kind;
        hci_h4_pkg::t_type_dec      dec;
        logic [hci_h4_pkg::HDR_KEEP-1:0][7:0] hdr;
        logic                       cmd_baud;
        logic                       evt_baud;
        logic                       evt_fw;

        n_st        = cur_st;
        n_pend_baud = r_pend_baud;
        n_o_vld     = 1'b0;
        n_o_first   = 1'b0;
        n_o_last    = 1'b0;
        n_o_kind    = hci_h4_pkg::KIND_CMD;
        n_o_inc     = cur_st.dir;
        n_o_len     = '0;
        n_o_err     = hci_h4_pkg::ERR_NONE;
        n_o_act     = hci_h4_pkg::BAUD_NONE;
        n_o_baud    = '0;

        pos     = cur_st.cnt;
        hunt    = (pos == '0);
        dec     = hci_h4_pkg::decode_type(r_s1_byte);
        kind    = hunt ? dec.kind : cur_st.kind;
        dir     = cur_st.dir;
        exp_len = hunt ? '0 : cur_st.exp_len;
        hdr     = cur_st.hdr;
        acl_len = AclW'(cur_st.len_lo) + {1'b0, r_s1_byte, 8'h00} + AclW'(5);
        len_err = 1'b0;
        pos1    = pos + CntW'(1);

        if (hunt && r_s1_byte == hci_h4_pkg::H4_CMD) begin
            dir = 1'b0;
        end else if (hunt && r_s1_byte == hci_h4_pkg::H4_EVT) begin
            dir = 1'b1;
        end
        if (pos < CntW'(hci_h4_pkg::HDR_KEEP)) begin
            hdr[pos[HdrIdxW-1:0]] = r_s1_byte;
        end

        if (exp_len == '0) begin
            priority if ((kind == hci_h4_pkg::KIND_CMD || kind == hci_h4_pkg::KIND_SCO)
                         && pos == CntW'(3)) begin
                exp_len = CntW'(r_s1_byte) + CntW'(4);
            end else if ((kind == hci_h4_pkg::KIND_EVT || kind == hci_h4_pkg::KIND_VENDOR)
                         && pos == CntW'(2)) begin
                exp_len = CntW'(r_s1_byte) + CntW'(3);
            end else if (kind == hci_h4_pkg::KIND_ACL && pos == CntW'(3)) begin
                n_st.len_lo = r_s1_byte;
            end else if (kind == hci_h4_pkg::KIND_ACL && pos == CntW'(4)) begin
                if (acl_len > AclW'(MAX_PACKET)) begin
                    len_err = 1'b1;
                end else begin
                    exp_len = CntW'(acl_len);
                end
            end else begin
                exp_len = '0;
            end
        end

        last = (exp_len != '0) && (pos1 >= exp_len);

        cmd_baud = hdr[0] == hci_h4_pkg::H4_CMD && hdr[1] == hci_h4_pkg::OCF_SET_BAUD
                && hdr[2] == hci_h4_pkg::OGF_VENDOR && hdr[3] == hci_h4_pkg::CMD_BAUD_PLEN;
        evt_baud = hdr[0] == hci_h4_pkg::H4_EVT && hdr[2] == hci_h4_pkg::EVT_CPL_PLEN
                && hdr[3] == hci_h4_pkg::NUM_CMD_PKTS && hdr[4] == hci_h4_pkg::OCF_SET_BAUD
                && hdr[5] == hci_h4_pkg::OGF_VENDOR;
        evt_fw   = hdr[0] == hci_h4_pkg::H4_EVT && hdr[1] == hci_h4_pkg::EVT_CMD_CPL
                && hdr[2] == hci_h4_pkg::EVT_CPL_PLEN && hdr[3] == hci_h4_pkg::NUM_CMD_PKTS
                && hdr[4] == hci_h4_pkg::OCF_FW_DONE && hdr[5] == hci_h4_pkg::OGF_VENDOR
                && hdr[6] == hci_h4_pkg::STATUS_OK;

        priority if (!line_ok) begin
            n_o_vld = 1'b0;
        end else if (hunt && r_s1_byte == hci_h4_pkg::H4_PAD) begin
            n_o_vld = 1'b0;
        end else if (hunt && !dec.ok) begin
            n_o_vld = 1'b1;
            n_o_err = hci_h4_pkg::ERR_TYPE;
        end else if (len_err) begin
            n_o_vld      = 1'b1;
            n_o_err      = hci_h4_pkg::ERR_LEN;
            n_o_kind     = kind;
            n_o_inc      = dir;
            n_st.cnt     = '0;
            n_st.exp_len = '0;
            n_st.kind    = kind;
            n_st.dir     = dir;
            n_st.hdr     = hdr;
        end else begin
            n_o_vld   = 1'b1;
            n_o_first = hunt;
            n_o_last  = last;
            n_o_kind  = kind;
            n_o_inc   = dir;
            n_o_len   = hci_h4_pkg::LEN_W'(exp_len);
            if (last) begin
                priority if (cmd_baud) begin
                    n_pend_baud = {hdr[8], hdr[7], hdr[6]};
                end else if (evt_baud) begin
                    if (hdr[1] == hci_h4_pkg::EVT_CMD_CPL && hdr[6] == hci_h4_pkg::STATUS_OK)
                    begin
                        if (r_pend_baud != '0) begin
                            n_o_act  = hci_h4_pkg::BAUD_SWITCH;
                            n_o_baud = r_pend_baud;
                        end
                    end else begin
                        n_o_act = hci_h4_pkg::BAUD_FAIL;
                    end
                end else if (evt_fw) begin
                    n_o_act  = hci_h4_pkg::BAUD_REVERT;
                    n_o_baud = r_fallback;
                end else begin
                    n_o_act = hci_h4_pkg::BAUD_NONE;
                end
            end
            n_st.cnt     = last ? '0 : pos1;
            n_st.exp_len = last ? '0 : exp_len;
            n_st.kind    = kind;
            n_st.dir     = dir;
            n_st.hdr     = hdr;
        end
    end

    // Line-state memory
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd <= r_mem[in_addr];
        end
        if (wr_en) begin
            r_mem[s1_addr] <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_s1_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_pend_baud <= '0;
            r_fallback  <= hci_h4_pkg::FALLBACK_BAUD_RST;
            r_o_vld     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[s1_addr] <= 1'b1;
                r_pend_baud    <= n_pend_baud;
            end
            if (in_fire) begin
                r_s1_vld  <= 1'b1;
                r_fwd_vld <= wr_en;
            end else if (s1_adv) begin
                r_s1_vld  <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_fallback <= i_cfg.fallback_baud;
            end
            if (s1_adv) begin
                r_o_vld <= n_o_vld;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_line  <= i_in.line_index;
            r_s1_byte  <= i_in.data_byte;
            r_fwd_line <= r_s1_line;
            r_fwd      <= n_st;
        end
        if (s1_adv && n_o_vld) begin
            r_o_line  <= r_s1_line;
            r_o_byte  <= r_s1_byte;
            r_o_first <= n_o_first;
            r_o_last  <= n_o_last;
            r_o_kind  <= n_o_kind;
            r_o_inc   <= n_o_inc;
            r_o_len   <= n_o_len;
            r_o_err   <= n_o_err;
            r_o_act   <= n_o_act;
            r_o_baud  <= n_o_baud;
        end
    end

    assign o_out.valid           = r_o_vld;
    assign o_out.out_line        = r_o_line;
    assign o_out.out_byte        = r_o_byte;
    assign o_out.first_of_packet = r_o_first;
    assign o_out.last_of_packet  = r_o_last;
    assign o_out.packet_kind     = r_o_kind;
    assign o_out.incoming        = r_o_inc;
    assign o_out.packet_length   = r_o_len;
    assign o_out.error_code      = r_o_err;
    assign o_out.baud_action     = r_o_act;
    assign o_out.baud_value      = r_o_baud;

endmodule

[hw/rtl/hci_h4_chk.sv]
// Port-level checker for the HCI H4 deframer, bound to the top level.
// Depends on hci_h4_pkg.
module hci_h4_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [hci_h4_pkg::LINE_W-1:0]      i_out_line,
    input logic [hci_h4_pkg::BYTE_W-1:0]      i_out_byte,
    input logic                               i_first,
    input logic                               i_last,
    input logic [hci_h4_pkg::KIND_W-1:0]      i_kind,
    input logic [hci_h4_pkg::LEN_W-1:0]       i_len,
    input logic [hci_h4_pkg::ERR_W-1:0]       i_err,
    input logic [hci_h4_pkg::ACT_W-1:0]       i_act
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_out_line, i_out_byte, i_first, i_last, i_err}))
        else $error("result word changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err != hci_h4_pkg::ERR_NONE |->
            !i_first && !i_last && i_len == '0 && i_act == hci_h4_pkg::BAUD_NONE)
        else $error("error word carries packet marks");

    a_first_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_first || i_last) |-> i_err == hci_h4_pkg::ERR_NONE)
        else $error("packet mark on error word");

    a_baud_evt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_act != hci_h4_pkg::BAUD_NONE |->
            i_last && i_kind == hci_h4_pkg::KIND_EVT)
        else $error("baud action outside last byte of event");

endmodule

bind hci_h4_packet_deframer_unit hci_h4_chk u_hci_h4_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_line  (o_out.out_line),
    .i_out_byte  (o_out.out_byte),
    .i_first     (o_out.first_of_packet),
    .i_last      (o_out.last_of_packet),
    .i_kind      (o_out.packet_kind),
    .i_len       (o_out.packet_length),
    .i_err       (o_out.error_code),
    .i_act       (o_out.baud_action)
);

[tb/sv/hci_h4_packet_deframer_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hci_h4_packet_deframer_unit: drives H4 byte streams on two lines,
// predicts every result word in a scoreboard class and compares it field by field.
// Depends on hci_h4_pkg, the channel interfaces in hci_h4_if.sv and the deframer top level.
module hci_h4_packet_deframer_unit_test;
    import hci_h4_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 60;

    typedef struct {
        logic               line;
        logic [BYTE_W-1:0]  data;
        logic               first;
        logic               last;
        t_kind              kind;
        logic               incoming;
        logic [LEN_W-1:0]   len;
        t_err               err;
        t_baud_act          act;
        logic [BAUD_W-1:0]  baud;
    } h4_word_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_LONG} rx_mode_t;

    class h4_frame_tracker;
        logic [BAUD_W-1:0] fallback;
        logic [BAUD_W-1:0] pending_baud;
        int unsigned       count [NUM_LINES_DEF];
        int unsigned       total_len [NUM_LINES_DEF];
        t_kind             kind [NUM_LINES_DEF];
        logic              dir [NUM_LINES_DEF];
        logic [7:0]        len_lo [NUM_LINES_DEF];
        logic [7:0]        hdr [NUM_LINES_DEF][HDR_KEEP];
        h4_word_t          expected_words [$];
        int                failures;
        int                words_checked;
        int                packets_closed;
        int                type_errors;
        int                length_errors;
        int                act_count [4];

        function new();
            fallback     = FALLBACK_BAUD_RST;
            pending_baud = '0;
            for (int i = 0; i < NUM_LINES_DEF; i++) begin
                count[i]     = 0;
                total_len[i] = 0;
                kind[i]      = KIND_CMD;
                dir[i]       = 1'b0;
                len_lo[i]    = '0;
                for (int k = 0; k < HDR_KEEP; k++) hdr[i][k] = '0;
            end
            failures       = 0;
            words_checked  = 0;
            packets_closed = 0;
            type_errors    = 0;
            length_errors  = 0;
            for (int i = 0; i < 4; i++) act_count[i] = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function bit note_input(logic ln, logic [7:0] b);
            h4_word_t    w;
            int unsigned pos;
            int unsigned acl_len;
            bit          lst;
            pos        = count[ln];
            w.line     = ln;
            w.data     = b;
            w.first    = 1'b0;
            w.last     = 1'b0;
            w.kind     = KIND_CMD;
            w.len      = '0;
            w.err      = ERR_NONE;
            w.act      = BAUD_NONE;
            w.baud     = '0;
            if (pos == 0) begin
                if (b == H4_PAD) return 1'b0;
                case (b)
                    H4_CMD: begin
                        kind[ln] = KIND_CMD;
                        dir[ln]  = 1'b0;
                    end
                    H4_ACL:    kind[ln] = KIND_ACL;
                    H4_SCO:    kind[ln] = KIND_SCO;
                    H4_EVT: begin
                        kind[ln] = KIND_EVT;
                        dir[ln]  = 1'b1;
                    end
                    H4_VENDOR: kind[ln] = KIND_VENDOR;
                    default: begin
                        w.err      = ERR_TYPE;
                        w.incoming = dir[ln];
                        expected_words.push_back(w);
                        type_errors++;
                        return 1'b1;
                    end
                endcase
                total_len[ln] = 0;
            end
            w.kind     = kind[ln];
            w.first    = (pos == 0);
            w.incoming = dir[ln];
            if (pos < HDR_KEEP) hdr[ln][pos] = b;
            if (total_len[ln] == 0) begin
                if ((kind[ln] == KIND_CMD || kind[ln] == KIND_SCO) && pos == 3) begin
                    total_len[ln] = int'(b) + 4;
                end else if ((kind[ln] == KIND_EVT || kind[ln] == KIND_VENDOR) && pos == 2) begin
                    total_len[ln] = int'(b) + 3;
                end else if (kind[ln] == KIND_ACL && pos == 3) begin
                    len_lo[ln] = b;
                end else if (kind[ln] == KIND_ACL && pos == 4) begin
                    acl_len = int'(len_lo[ln]) + (int'(b) << 8) + 5;
                    if (acl_len > MAX_PACKET_DEF) begin
                        count[ln]     = 0;
                        total_len[ln] = 0;
                        w.first       = 1'b0;
                        w.err         = ERR_LEN;
                        expected_words.push_back(w);
                        length_errors++;
                        return 1'b1;
                    end
                    total_len[ln] = acl_len;
                end
            end
            pos++;
            lst = (total_len[ln] != 0) && (pos >= total_len[ln]);
            if (lst) begin
                if (hdr[ln][0] == H4_CMD && hdr[ln][1] == OCF_SET_BAUD &&
                    hdr[ln][2] == OGF_VENDOR && hdr[ln][3] == CMD_BAUD_PLEN) begin
                    pending_baud = {hdr[ln][8], hdr[ln][7], hdr[ln][6]};
                end else if (hdr[ln][0] == H4_EVT && hdr[ln][2] == EVT_CPL_PLEN &&
                             hdr[ln][3] == NUM_CMD_PKTS && hdr[ln][4] == OCF_SET_BAUD &&
                             hdr[ln][5] == OGF_VENDOR) begin
                    if (hdr[ln][1] == EVT_CMD_CPL && hdr[ln][6] == STATUS_OK) begin
                        if (pending_baud != 0) begin
                            w.act  = BAUD_SWITCH;
                            w.baud = pending_baud;
                        end
                    end else begin
                        w.act = BAUD_FAIL;
                    end
                end else if (hdr[ln][0] == H4_EVT && hdr[ln][1] == EVT_CMD_CPL &&
                             hdr[ln][2] == EVT_CPL_PLEN && hdr[ln][3] == NUM_CMD_PKTS &&
                             hdr[ln][4] == OCF_FW_DONE && hdr[ln][5] == OGF_VENDOR &&
                             hdr[ln][6] == STATUS_OK) begin
                    w.act  = BAUD_REVERT;
                    w.baud = fallback;
                end
                packets_closed++;
                act_count[w.act]++;
            end
            w.last = lst;
            w.len  = LEN_W'(total_len[ln]);
            expected_words.push_back(w);
            if (lst) begin
                count[ln]     = 0;
                total_len[ln] = 0;
            end else begin
                count[ln] = pos;
            end
            return 1'b1;
        endfunction

        function void cmp(string field, logic [23:0] e, logic [23:0] a);
            if (a !== e) begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: mismatch on %s: expected %0h actual %0h", $time, field, e, a);
            end
        endfunction

        function void check_result(h4_word_t got);
            h4_word_t exp;
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: unexpected word: expected none actual line %0h byte %0h",
                             $time, got.line, got.data);
                return;
            end
            exp = expected_words.pop_front();
            words_checked++;
            cmp("out_line",        24'(exp.line),     24'(got.line));
            cmp("out_byte",        24'(exp.data),     24'(got.data));
            cmp("first_of_packet", 24'(exp.first),    24'(got.first));
            cmp("last_of_packet",  24'(exp.last),     24'(got.last));
            cmp("packet_kind",     24'(exp.kind),     24'(got.kind));
            cmp("incoming",        24'(exp.incoming), 24'(got.incoming));
            cmp("packet_length",   24'(exp.len),      24'(got.len));
            cmp("error_code",      24'(exp.err),      24'(got.err));
            cmp("baud_action",     24'(exp.act),      24'(got.act));
            cmp("baud_value",      exp.baud,          got.baud);
        endfunction

        function void close_out();
            if (expected_words.size() != 0) begin
                failures++;
                $display("%0t: %0d expected words never arrived", $time, expected_words.size());
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hci_h4_in_if  in_if ();
    hci_h4_out_if out_if ();
    hci_h4_cfg_if cfg_if ();

    hci_h4_packet_deframer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    h4_frame_tracker tracker = new();

    int         cycle_count     = 0;
    int         burst_left      = 0;
    int         frames_built    = 0;
    bit         long_frame_done = 1'b0;
    int         fallback_writes = 0;
    logic [7:0] line0_bytes [$];
    logic [7:0] line1_bytes [$];
    rx_mode_t   ready_mode      = RX_OPEN;
    int         ready_span      = 0;
    logic [31:0] ready_pat      = 32'h1;

    localparam logic [8:0] DIRECTED [27] = '{
        {1'b0, H4_PAD},
        {1'b0, 8'h05},
        {1'b1, H4_EVT}, {1'b1, EVT_CMD_CPL}, {1'b1, 8'h00},
        {1'b0, H4_CMD}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'h00},
        {1'b1, 8'haa},
        {1'b1, H4_VENDOR}, {1'b1, 8'h80}, {1'b1, 8'h00},
        {1'b0, H4_SCO}, {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h00},
        {1'b1, H4_ACL}, {1'b1, 8'h00}, {1'b1, 8'h00}, {1'b1, 8'hfc}, {1'b1, 8'h1f},
        {1'b0, H4_ACL}, {1'b0, 8'h34}, {1'b0, 8'h12}, {1'b0, 8'h00}, {1'b0, 8'h00}
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("hci_h4_packet_deframer_unit regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        h4_word_t seen;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen.line     = out_if.out_line;
            seen.data     = out_if.out_byte;
            seen.first    = out_if.first_of_packet;
            seen.last     = out_if.last_of_packet;
            seen.kind     = t_kind'(out_if.packet_kind);
            seen.incoming = out_if.incoming;
            seen.len      = out_if.packet_length;
            seen.err      = t_err'(out_if.error_code);
            seen.act      = t_baud_act'(out_if.baud_action);
            seen.baud     = out_if.baud_value;
            tracker.check_result(seen);
        end
    end

    // receiver back-pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_span == 0) begin
                ready_mode = rx_mode_t'($urandom_range(0, 3));
                ready_span = $urandom_range(64, 400);
                ready_pat  = $urandom | 32'h1;
            end
            ready_span--;
            case (ready_mode)
                RX_OPEN:   out_if.ready <= 1'b1;
                RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: begin
                    out_if.ready <= ready_pat[0];
                    ready_pat = {ready_pat[0], ready_pat[31:1]};
                end
                default:   out_if.ready <= ((ready_span % 48) >= 12);
            endcase
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void put(logic ln, logic [7:0] b);
        if (ln) line1_bytes.push_back(b);
        else    line0_bytes.push_back(b);
    endfunction

    function automatic logic [7:0] type_byte();
        case ($urandom_range(0, 4))
            0:       return H4_CMD;
            1:       return H4_ACL;
            2:       return H4_SCO;
            3:       return H4_EVT;
            default: return H4_VENDOR;
        endcase
    endfunction

    function automatic void queue_frame(logic ln);
        int unsigned pick;
        int unsigned plen;
        int unsigned idx;
        logic [7:0]  fw [7];
        frames_built++;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        if (!long_frame_done && frames_built > 200) begin
            // largest legal ACL packet
            long_frame_done = 1'b1;
            put(ln, H4_ACL); put(ln, rnd8()); put(ln, rnd8());
            put(ln, 8'hfb); put(ln, 8'h1f);
            repeat (MAX_PACKET_DEF - 5) put(ln, rnd8());
        end else if (pick < 8) begin
            repeat ($urandom_range(1, 4)) put(ln, ($urandom_range(0, 1) != 0) ? H4_PAD : rnd8());
        end else if (pick < 13) begin
            put(ln, type_byte());
            repeat ($urandom_range(1, 3)) put(ln, rnd8());
        end else if (pick < 22) begin
            put(ln, H4_CMD); put(ln, OCF_SET_BAUD); put(ln, OGF_VENDOR); put(ln, CMD_BAUD_PLEN);
            repeat (3) put(ln, rnd8());
            if ($urandom_range(0, 5) == 0) repeat (3) put(ln, 8'h00);
            else                           repeat (3) put(ln, rnd8());
        end else if (pick < 30) begin
            put(ln, H4_EVT);
            put(ln, ($urandom_range(0, 5) == 0) ? rnd8() : EVT_CMD_CPL);
            put(ln, EVT_CPL_PLEN); put(ln, NUM_CMD_PKTS); put(ln, OCF_SET_BAUD);
            put(ln, OGF_VENDOR);
            put(ln, ($urandom_range(0, 4) == 0) ? rnd8() : STATUS_OK);
        end else if (pick < 36) begin
            fw = '{H4_EVT, EVT_CMD_CPL, EVT_CPL_PLEN, NUM_CMD_PKTS, OCF_FW_DONE, OGF_VENDOR,
                   STATUS_OK};
            if ($urandom_range(0, 4) == 0) begin
                idx = $urandom_range(0, 4);
                idx = (idx == 0) ? 1 : idx + 2;
                fw[idx] = rnd8();
            end
            foreach (fw[i]) put(ln, fw[i]);
        end else begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    put(ln, ($urandom_range(0, 1) != 0) ? H4_CMD : H4_SCO);
                    put(ln, rnd8()); put(ln, rnd8()); put(ln, 8'(plen));
                    repeat (plen) put(ln, rnd8());
                end
                2: begin
                    put(ln, ($urandom_range(0, 1) != 0) ? H4_EVT : H4_VENDOR);
                    put(ln, rnd8()); put(ln, 8'(plen));
                    repeat (plen) put(ln, rnd8());
                end
                default: begin
                    put(ln, H4_ACL); put(ln, rnd8()); put(ln, rnd8());
                    idx = $urandom_range(0, 14);
                    if (idx == 0) begin
                        put(ln, rnd8()); put(ln, 8'($urandom_range(32, 255)));
                    end else if (idx == 1) begin
                        put(ln, 8'hfc); put(ln, 8'h1f);
                    end else begin
                        put(ln, 8'(plen)); put(ln, 8'h00);
                        repeat (plen) put(ln, rnd8());
                    end
                end
            endcase
        end
    endfunction

    task automatic send_byte(logic ln, logic [7:0] b, output bit produced);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(100, 300);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 5);
            end
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid      <= 1'b1;
        in_if.line_index <= ln;
        in_if.data_byte  <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        produced = tracker.note_input(ln, b);
    endtask

    task automatic settle_block();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_fallback(logic [BAUD_W-1:0] v);
        cfg_if.valid         <= 1'b1;
        cfg_if.fallback_baud <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        tracker.fallback = v;
        fallback_writes++;
    endtask

    task automatic run_directed();
        bit r;
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][8], DIRECTED[i][7:0], r);
    endtask

    task automatic run_random(int n);
        int         made;
        logic       ln;
        logic [7:0] b;
        bit         r;
        made = 0;
        while (made < n || line0_bytes.size() != 0 || line1_bytes.size() != 0) begin
            if (made >= n) ln = (line0_bytes.size() != 0) ? 1'b0 : 1'b1;
            else           ln = 1'($urandom_range(0, 1));
            if (ln == 1'b0 && line0_bytes.size() == 0) queue_frame(ln);
            if (ln == 1'b1 && line1_bytes.size() == 0) queue_frame(ln);
            b = ln ? line1_bytes.pop_front() : line0_bytes.pop_front();
            send_byte(ln, b, r);
            if (r) made++;
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.line_index     <= '0;
        in_if.data_byte      <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.fallback_baud <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(150);
        settle_block();
        run_random(150);
        settle_block();
        write_fallback(24'hffffff);
        run_random(400);
        settle_block();
        write_fallback(24'h000000);
        run_random(300);
        settle_block();
        write_fallback(24'($urandom_range(1, 24'hfffffe)));
        run_random(250);
        settle_block();
        write_fallback(24'd921600);
        run_random(300);
        settle_block();
        tracker.close_out();

        $display("checked %0d words, %0d complete packets, %0d bad type bytes, %0d oversize ACL",
                 tracker.words_checked, tracker.packets_closed, tracker.type_errors,
                 tracker.length_errors);
        $display("baud actions none/switch/fail/revert %0d/%0d/%0d/%0d over %0d fallback settings",
                 tracker.act_count[BAUD_NONE], tracker.act_count[BAUD_SWITCH],
                 tracker.act_count[BAUD_FAIL], tracker.act_count[BAUD_REVERT],
                 fallback_writes + 1);
        if (tracker.failures == 0) begin
            $display("hci_h4_packet_deframer_unit regression: pass");
        end else begin
            $display("hci_h4_packet_deframer_unit regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/hci_h4_pkg.sv
hw/rtl/hci_h4_if.sv
hw/rtl/hci_h4_packet_deframer_unit.sv
hw/rtl/hci_h4_chk.sv
tb/sv/hci_h4_packet_deframer_unit_test.sv
